>>> rtl/gr_pkg.sv
package gr_pkg;

   // Widest group count the design supports (MAX_GROUP up to 127).
   localparam int CNT_W = 7;

   // Width of the group size register.
   localparam int SIZE_W = 5;

   localparam int DATA_W = 32;

   // One finished group, handed from the front end to the back end.
   typedef struct packed {
      logic             bank;
      logic [CNT_W-1:0] count;
      logic             reversed;
      logic             last_of_list;
   } grp_cmd_type;

endpackage

>>> rtl/gr_front.sv
module gr_front import gr_pkg::*; #(
   parameter int MAX_GROUP = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [SIZE_W-1:0]    group_size,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [DATA_W-1:0]    req_tdata,
   input  logic                 req_tlast,
   input  logic                 cmd_full,
   output logic                 cmd_push,
   output grp_cmd_type          cmd_data,
   output logic                 wr_en,
   output logic [$clog2(MAX_GROUP):0] wr_addr,
   output logic [DATA_W-1:0]    wr_data
);

   localparam int AW = $clog2(MAX_GROUP);
   localparam int CW = $clog2(MAX_GROUP + 1);
   localparam int KW = (CW > SIZE_W) ? CW : SIZE_W;
   localparam logic [KW-1:0] MAX_K = KW'(MAX_GROUP);

   logic [CW-1:0] fill_ff, fill_in;
   logic          bank_ff, bank_in;
   logic [CW-1:0] fill_next;
   logic [KW-1:0] size_ext, k_eff;
   logic          accept, complete, flush;

   assign req_tready = !cmd_full;
   assign accept     = req_tvalid && req_tready;
   assign fill_next  = fill_ff + CW'(1);

   always_comb begin
      size_ext = KW'(group_size);
      if (size_ext == '0) begin
         k_eff = KW'(1);
      end else if (size_ext > MAX_K) begin
         k_eff = MAX_K;
      end else begin
         k_eff = size_ext;
      end
   end

   assign complete = KW'(fill_next) >= k_eff;
   assign flush    = complete || req_tlast;

   // fill_ff never reaches MAX_GROUP before a write, so the low bits index the bank
   assign wr_en   = accept;
   assign wr_addr = {bank_ff, fill_ff[AW-1:0]};
   assign wr_data = req_tdata;

   assign cmd_push              = accept && flush;
   assign cmd_data.bank         = bank_ff;
   assign cmd_data.count        = CNT_W'(fill_next);
   assign cmd_data.reversed     = complete;
   assign cmd_data.last_of_list = req_tlast;

   always_comb begin
      fill_in = fill_ff;
      bank_in = bank_ff;
      if (accept) begin
         if (flush) begin
            fill_in = '0;
            bank_in = !bank_ff;
         end else begin
            fill_in = fill_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         bank_ff <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         bank_ff <= bank_in;
      end
   end

endmodule

>>> rtl/gr_cmd_fifo.sv
module gr_cmd_fifo import gr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  grp_cmd_type push_data,
   output logic        full,
   input  logic        pop,
   output logic        not_empty,
   output grp_cmd_type head
);

   grp_cmd_type slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full      = count_ff == 2'd2;
   assign not_empty = count_ff != 2'd0;
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/gr_back.sv
module gr_back import gr_pkg::*; #(
   parameter int MAX_GROUP = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_en,
   input  logic [$clog2(MAX_GROUP):0] wr_addr,
   input  logic [DATA_W-1:0]    wr_data,
   input  logic                 cmd_valid,
   input  grp_cmd_type          cmd_data,
   output logic                 cmd_pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [DATA_W-1:0]    rsp_tdata,
   output logic                 rsp_tuser,
   output logic                 rsp_tlast
);

   localparam int AW    = $clog2(MAX_GROUP);
   localparam int CW    = $clog2(MAX_GROUP + 1);
   localparam int DEPTH = 2 ** (AW + 1);

   // two banks: front end fills one while this side drains the other
   logic [DATA_W-1:0] mem [DEPTH];

   logic [CW-1:0]     idx_ff, idx_in;
   logic              valid_ff, valid_in;
   logic              run_ff, run_in;
   logic              list_ff, list_in;
   logic [DATA_W-1:0] rd_data_ff;

   logic [CW-1:0]     count, src;
   logic [AW:0]       rd_addr;
   logic              room, advance, final_word;

   assign count      = cmd_data.count[CW-1:0];
   assign src        = cmd_data.reversed ? (count - CW'(1) - idx_ff) : idx_ff;
   assign rd_addr    = {cmd_data.bank, src[AW-1:0]};
   assign final_word = (idx_ff + CW'(1)) == count;

   assign room    = !valid_ff || rsp_tready;
   assign advance = cmd_valid && room;
   assign cmd_pop = advance && final_word;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      run_in   = run_ff;
      list_in  = list_ff;
      if (room) begin
         valid_in = cmd_valid;
      end
      if (advance) begin
         run_in  = final_word;
         list_in = final_word && cmd_data.last_of_list;
         idx_in  = final_word ? '0 : idx_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
         run_ff   <= 1'b0;
         list_ff  <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
         run_ff   <= run_in;
         list_ff  <= list_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (advance) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = rd_data_ff;
   assign rsp_tuser  = run_ff;
   assign rsp_tlast  = list_ff;

endmodule

>>> rtl/group_reverse_stream.sv
// Reverses a stream of signed 32-bit words in groups of csr_wr_data words
// (1..MAX_GROUP; 0 acts as 1, larger values saturate). A full group is sent
// newest first; a short group closed by req_tlast is sent in arrival order.
// rsp_tuser flags the last word of each group and rsp_tlast the last word of
// the list. Words are buffered in a two-bank memory: the front end fills one
// bank while the back end drains the other through a two-entry group queue,
// so one word per cycle is sustained in both directions while the output is
// ready. With the back end idle, the group closed by an accepted input word
// is registered in the group queue, then its first word is read into the
// output register; the rest follow one per cycle. Input stalls only when
// both banks hold groups not yet drained, e.g. when the output side stalls.
// Write the group size only while the block is idle.
module group_reverse_stream import gr_pkg::*; #(
   parameter int MAX_GROUP = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data,   // group_size
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,     // element
   input  logic              req_tlast,     // end_of_list
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [DATA_W-1:0] rsp_tdata,     // out_element
   output logic              rsp_tuser,     // last_of_run
   output logic              rsp_tlast      // last_of_list
);

   localparam int AW = $clog2(MAX_GROUP);
   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(2);

   logic [SIZE_W-1:0] group_size_ff, group_size_in;

   logic              cmd_full, cmd_push, cmd_pop, cmd_valid;
   grp_cmd_type       push_data, head;
   logic              wr_en;
   logic [AW:0]       wr_addr;
   logic [DATA_W-1:0] wr_data;

   assign group_size_in = csr_wr_en ? csr_wr_data : group_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         group_size_ff <= SIZE_RESET;
      end else begin
         group_size_ff <= group_size_in;
      end
   end

   gr_front #(.MAX_GROUP(MAX_GROUP)) u_front (
      .clock      (clock),
      .reset      (reset),
      .group_size (group_size_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .cmd_full   (cmd_full),
      .cmd_push   (cmd_push),
      .cmd_data   (push_data),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data)
   );

   gr_cmd_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (push_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .not_empty (cmd_valid),
      .head      (head)
   );

   gr_back #(.MAX_GROUP(MAX_GROUP)) u_back (
      .clock      (clock),
      .reset      (reset),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .cmd_valid  (cmd_valid),
      .cmd_data   (head),
      .cmd_pop    (cmd_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> sim/group_reverse_checker.sv
module group_reverse_checker import gr_pkg::*; #(
   parameter int MAX_GROUP = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [SIZE_W-1:0] csr_wr_data,
   input  logic              req_tvalid,
   input  logic              req_tready,
   input  logic [DATA_W-1:0] req_tdata,
   input  logic              req_tlast,
   input  logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic [DATA_W-1:0] rsp_tdata,
   input  logic              rsp_tuser,
   input  logic              rsp_tlast,
   output int                mismatches,
   output int                outstanding
);

   typedef struct packed {
      logic [DATA_W-1:0] element;
      logic              run_end;
      logic              list_end;
   } out_word_type;

   out_word_type      pending_words[$];
   logic [DATA_W-1:0] held_words[MAX_GROUP];
   int                held_count;
   logic [SIZE_W-1:0] group_size;
   int                fail_count;

   function automatic int effective_size(input logic [SIZE_W-1:0] size);
      if (size == 0)
         return 1;
      if (size > MAX_GROUP)
         return MAX_GROUP;
      return int'(size);
   endfunction

   // Holds the word; once the group closes, queues its words in output order.
   task automatic absorb_word(input logic [DATA_W-1:0] data, input logic last);
      int           limit;
      bit           reversed;
      out_word_type w;
      limit = effective_size(group_size);
      if (held_count < MAX_GROUP) begin
         held_words[held_count] = data;
         held_count++;
      end
      if (held_count < limit && !last)
         return;
      // a lowered size can leave more than limit words held: all go out reversed
      reversed = (held_count >= limit);
      for (int i = 0; i < held_count; i++) begin
         w.element  = held_words[reversed ? held_count - 1 - i : i];
         w.run_end  = (i == held_count - 1);
         w.list_end = w.run_end && last;
         pending_words.insert(pending_words.size(), w);
      end
      held_count = 0;
   endtask

   always @(posedge clock) begin
      out_word_type want;
      if (reset) begin
         pending_words.delete();
         held_count = 0;
         group_size = SIZE_W'(2);
         fail_count = 0;
      end else begin
         if (csr_wr_en)
            group_size = csr_wr_data;
         if (req_tvalid && req_tready)
            absorb_word(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (pending_words.size() == 0) begin
               $display("%0t: unexpected word: expected none, actual %0d user %b last %b",
                        $time, $signed(rsp_tdata), rsp_tuser, rsp_tlast);
               fail_count++;
            end else begin
               want = pending_words.pop_front();
               if (rsp_tdata !== want.element) begin
                  $display("%0t: element mismatch: expected %0d, actual %0d",
                           $time, $signed(want.element), $signed(rsp_tdata));
                  fail_count++;
               end
               if (rsp_tuser !== want.run_end) begin
                  $display("%0t: last_of_run mismatch: expected %b, actual %b",
                           $time, want.run_end, rsp_tuser);
                  fail_count++;
               end
               if (rsp_tlast !== want.list_end) begin
                  $display("%0t: last_of_list mismatch: expected %b, actual %b",
                           $time, want.list_end, rsp_tlast);
                  fail_count++;
               end
            end
         end
      end
      mismatches  <= fail_count;
      outstanding <= pending_words.size();
   end

endmodule

>>> sim/testbench.sv
module testbench;
   import gr_pkg::*;

   localparam int MAX_GROUP    = 16;
   localparam int LIMIT_CYCLES = 100000;
   localparam int DRAIN_CYCLES = 10;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              csr_wr_en   = 1'b0;
   logic [SIZE_W-1:0] csr_wr_data = '0;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata   = '0;   // element
   logic              req_tlast   = 1'b0; // end_of_list
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;          // out_element
   logic              rsp_tuser;          // last_of_run
   logic              rsp_tlast;          // last_of_list

   int mismatches;
   int outstanding;
   int cycle_count     = 0;
   int feed_gap_pct    = 31;
   int drain_stall_pct = 67;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   group_reverse_stream #(.MAX_GROUP(MAX_GROUP)) i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   group_reverse_checker #(.MAX_GROUP(MAX_GROUP)) i_check (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always @(posedge clock)
      rsp_tready <= !reset && ($urandom_range(99) >= drain_stall_pct);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("FAIL group_reverse_stream");
         $finish;
      end
   end

   function automatic logic [DATA_W-1:0] pick_element();
      case ($urandom_range(7))
         0:       return 32'h8000_0000;
         1:       return 32'h7fff_ffff;
         2:       return 32'h0000_0000;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // mostly small groups, now and then zero, one, full or oversized
   function automatic logic [SIZE_W-1:0] pick_size();
      case ($urandom_range(9))
         0:       return SIZE_W'(0);
         1:       return SIZE_W'(1);
         2:       return SIZE_W'(MAX_GROUP);
         3:       return SIZE_W'(17 + $urandom_range(14));
         default: return SIZE_W'($urandom_range(2, 6));
      endcase
   endfunction

   // valid stays up after a handshake; it drops only for a gap or an idle wait
   task automatic send_word(input logic [DATA_W-1:0] data, input logic last);
      while ($urandom_range(99) < feed_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_group_size(input logic [SIZE_W-1:0] size);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= size;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      int  sent;
      int  list_len;
      bit  closed;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset size of two: extremes reversed, then a lone word closed by end flag
      send_word(32'h8000_0000, 1'b0);
      send_word(32'h7fff_ffff, 1'b0);
      send_word(32'hffff_ffff, 1'b1);
      // zero acts as one: full group together with end flag
      write_group_size(SIZE_W'(0));
      send_word(32'h0000_0000, 1'b1);
      // oversized saturates to a full 16-word group
      write_group_size(SIZE_W'(31));
      for (int i = 0; i < MAX_GROUP; i++)
         send_word(pick_element(), 1'b0);
      // short group closed by end flag keeps arrival order
      send_word(32'h1111_1111, 1'b0);
      send_word(32'h2222_2222, 1'b0);
      write_group_size(SIZE_W'(5));
      send_word(32'h3333_3333, 1'b1);
      // size lowered to the held count mid-group
      send_word(32'h4444_4444, 1'b0);
      send_word(32'h5555_5555, 1'b0);
      write_group_size(SIZE_W'(2));
      send_word(32'h6666_6666, 1'b0);

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               feed_gap_pct    = 31;
               drain_stall_pct = 67;
            end
            1: begin
               feed_gap_pct    = 67;
               drain_stall_pct = 31;
            end
            default: begin
               feed_gap_pct    = 0;
               drain_stall_pct = 0;
            end
         endcase
         sent = 0;
         while (sent < 22) begin
            write_group_size(pick_size());
            repeat ($urandom_range(1, 3)) begin
               list_len = $urandom_range(1, 12);
               // some lists stay open so the next size change hits a partial group
               closed = ($urandom_range(4) != 0);
               for (int j = 0; j < list_len; j++)
                  send_word(pick_element(), closed && (j == list_len - 1));
               sent += list_len;
            end
         end
      end

      wait_idle();
      if (mismatches == 0)
         $display("PASS group_reverse_stream");
      else
         $display("FAIL group_reverse_stream");
      $finish;
   end

endmodule
